### design/tapb_pkg.sv
`default_nettype none

package tapb_pkg;

    // Reset extent of the clip window
    localparam int MAX_DIM = 4096;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int WEIGHT_W    = 17;   // e(a)*e(b) reaches 65536
    localparam int WEIGHT_SH   = 16;   // weight is 1.16 fixed point
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COORD_W     = 16;
    localparam int CLIP_POS_W  = 12;
    localparam int CLIP_SPAN_W = 13;

    // Lane order inside a packed ARGB word: lane 3 is alpha (bits 31:24)
    localparam int LANE_A = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE  = 3'd0,
        REG_TINT_COLOR  = 3'd1,
        REG_CLIP_LEFT   = 3'd2,
        REG_CLIP_TOP    = 3'd3,
        REG_CLIP_SPAN_X = 3'd4,
        REG_CLIP_SPAN_Y = 3'd5
    } reg_idx_t;

    typedef enum logic {
        MODE_PLOT = 1'b0,
        MODE_TINT = 1'b1
    } blend_mode_t;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] argb_t;

    typedef struct packed {
        blend_mode_t             blend_mode;
        argb_t                   tint_color;
        logic [CLIP_POS_W-1:0]   clip_left;
        logic [CLIP_POS_W-1:0]   clip_top;
        logic [CLIP_SPAN_W-1:0]  clip_span_x;
        logic [CLIP_SPAN_W-1:0]  clip_span_y;
    } cfg_t;

    // Front stage result: per-lane target, common weight, clip decision, destination pixel
    typedef struct packed {
        logic                 in_window;
        logic [WEIGHT_W-1:0]  weight;
        argb_t                target;
        argb_t                dest;
    } front_t;

    // e(v) = v + (v > 0): maps 0..255 onto 0..256
    function automatic logic [CHAN_W:0] expand(input logic [CHAN_W-1:0] v);
        expand = {1'b0, v} + {{CHAN_W{1'b0}}, (v != '0)};
    endfunction

endpackage

`default_nettype wire

### design/tapb_cfg.sv
`default_nettype none

module tapb_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [tapb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tapb_pkg::CFG_DATA_W-1:0] cfg_data,
    output tapb_pkg::cfg_t                     cfg
);
    import tapb_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode  <= MODE_PLOT;
            cfg_reg.tint_color  <= '1;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_span_x <= CLIP_SPAN_W'(MAX_DIM);
            cfg_reg.clip_span_y <= CLIP_SPAN_W'(MAX_DIM);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:  cfg_reg.blend_mode  <= blend_mode_t'(cfg_data[0]);
                REG_TINT_COLOR:  cfg_reg.tint_color  <= cfg_data;
                REG_CLIP_LEFT:   cfg_reg.clip_left   <= cfg_data[CLIP_POS_W-1:0];
                REG_CLIP_TOP:    cfg_reg.clip_top    <= cfg_data[CLIP_POS_W-1:0];
                REG_CLIP_SPAN_X: cfg_reg.clip_span_x <= cfg_data[CLIP_SPAN_W-1:0];
                REG_CLIP_SPAN_Y: cfg_reg.clip_span_y <= cfg_data[CLIP_SPAN_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/tapb_front.sv
`default_nettype none

module tapb_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tapb_pkg::cfg_t                    cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [31:0]                       source_argb,
    input  wire logic [31:0]                       dest_argb,
    input  wire logic signed [tapb_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [tapb_pkg::COORD_W-1:0] pos_y,
    output logic                                   fr_valid,
    input  wire logic                              fr_ready,
    output tapb_pkg::front_t                       fr_data
);
    import tapb_pkg::*;

    localparam int CMP_W = COORD_W + 2;

    logic                    fr_valid_reg;
    front_t                  fr_data_reg;
    front_t                  fr_data_next;

    argb_t                   src;
    logic signed [CMP_W-1:0] x_ext, y_ext, lo_x, lo_y, hi_x, hi_y;
    logic [CHAN_W:0]         ea, wa;
    logic [2*CHAN_W+1:0]     w_prod;
    logic [2*CHAN_W:0]       t_prod [NUM_CHAN-1];

    assign src = source_argb;

    // Clip window test, all signed with headroom
    always_comb
    begin
        x_ext = {{(CMP_W-COORD_W){pos_x[COORD_W-1]}}, pos_x};
        y_ext = {{(CMP_W-COORD_W){pos_y[COORD_W-1]}}, pos_y};
        lo_x  = signed'({{(CMP_W-CLIP_POS_W){1'b0}}, cfg.clip_left});
        lo_y  = signed'({{(CMP_W-CLIP_POS_W){1'b0}}, cfg.clip_top});
        hi_x  = lo_x + signed'({{(CMP_W-CLIP_SPAN_W){1'b0}}, cfg.clip_span_x});
        hi_y  = lo_y + signed'({{(CMP_W-CLIP_SPAN_W){1'b0}}, cfg.clip_span_y});
    end

    // Weight: e(src_a)^2 in plot mode, e(tint_a)*e(src_a) when tinting
    always_comb
    begin
        ea     = expand(src[LANE_A]);
        wa     = (cfg.blend_mode == MODE_TINT) ? expand(cfg.tint_color[LANE_A]) : ea;
        w_prod = wa * ea;
    end

    always_comb
    begin
        fr_data_next.in_window = (x_ext >= lo_x) && (x_ext < hi_x) &&
                                 (y_ext >= lo_y) && (y_ext < hi_y);
        fr_data_next.weight = w_prod[WEIGHT_W-1:0];
        fr_data_next.dest   = dest_argb;
        // Alpha target is always the source alpha
        fr_data_next.target[LANE_A] = src[LANE_A];
        for (int i = 0; i < NUM_CHAN - 1; i++)
        begin
            t_prod[i] = expand(cfg.tint_color[i]) * src[i];
            fr_data_next.target[i] = (cfg.blend_mode == MODE_TINT) ?
                                     t_prod[i][2*CHAN_W-1:CHAN_W] : src[i];
        end
    end

    assign in_ready = !fr_valid_reg || fr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else if (in_ready)
            fr_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            fr_data_reg <= fr_data_next;
    end

    assign fr_valid = fr_valid_reg;
    assign fr_data  = fr_data_reg;

endmodule

`default_nettype wire

### design/tapb_mix.sv
`default_nettype none

module tapb_mix (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fr_valid,
    output logic                 fr_ready,
    input  wire tapb_pkg::front_t fr_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [31:0]          blended_argb,
    output logic                 write_enable
);
    import tapb_pkg::*;

    localparam int DIFF_W = CHAN_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

    // Product stage
    logic                      pr_valid_reg;
    logic                      pr_ready;
    logic                      pr_inside_reg;
    argb_t                     pr_dest_reg;
    argb_t                     pr_delta_reg;
    argb_t                     pr_delta_next;
    logic signed [DIFF_W-1:0]  diff [NUM_CHAN];
    logic signed [PROD_W-1:0]  prod [NUM_CHAN];

    // Output stage
    logic                      out_valid_reg;
    logic [31:0]               blended_reg;
    argb_t                     blended_next;
    logic                      write_enable_reg;

    // (target - dst) * weight; floor(/65536) is an arithmetic shift and only
    // its low byte survives the final mod 256
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            diff[i] = signed'({1'b0, fr_data.target[i]}) - signed'({1'b0, fr_data.dest[i]});
            prod[i] = diff[i] * signed'({1'b0, fr_data.weight});
            pr_delta_next[i] = prod[i][WEIGHT_SH +: CHAN_W];
        end
    end

    assign pr_ready = !out_valid_reg || out_ready;
    assign fr_ready = !pr_valid_reg || pr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_valid_reg <= 1'b0;
        else if (fr_ready)
            pr_valid_reg <= fr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fr_ready && fr_valid)
        begin
            pr_inside_reg <= fr_data.in_window;
            pr_dest_reg   <= fr_data.dest;
            pr_delta_reg  <= pr_delta_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
            blended_next[i] = pr_inside_reg ? (pr_dest_reg[i] + pr_delta_reg[i])
                                            : pr_dest_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pr_ready)
            out_valid_reg <= pr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pr_ready && pr_valid_reg)
        begin
            blended_reg      <= blended_next;
            write_enable_reg <= pr_inside_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign blended_argb = blended_reg;
    assign write_enable = write_enable_reg;

endmodule

`default_nettype wire

### design/tinted_alpha_pixel_blender.sv
`default_nettype none

// Tinted alpha pixel blender. Each input beat carries a source ARGB pixel,
// the current destination ARGB pixel and the signed destination coordinate;
// each output beat returns the blended pixel and write_enable, which is set
// when the coordinate lies in the clip window [clip_left, clip_left +
// clip_span_x) x [clip_top, clip_top + clip_span_y). Outside the window the
// destination pixel comes back unchanged. Weights use e(v) = v + (v > 0):
// plot mode (blend_mode 0) weighs by e(src_a)^2; tinted-blit mode weighs by
// e(tint_a)*e(src_a) and scales each color channel by e(tint_c)*src_c >> 8,
// alpha target staying the source alpha. Each channel becomes
// dst + floor((target - dst) * weight / 65536), modulo 256. Throughput is
// one pixel per clock while the output is not stalled; beats pass through
// the front stage (clip compare, 9x9 weight and 9x8 tint multipliers), the
// product stage (four 9x18 signed multipliers) and the output register.
// Stalls hold the pipeline stage by stage, so bubbles are squeezed out.
// Configuration is a plain write port (index 0 blend_mode, 1 tint_color,
// 2 clip_left, 3 clip_top, 4 clip_span_x, 5 clip_span_y; other indexes are
// ignored) and must only be written while no beat is in flight.
module tinted_alpha_pixel_blender (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [tapb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tapb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [31:0]                       source_argb,
    input  wire logic [31:0]                       dest_argb,
    input  wire logic signed [tapb_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [tapb_pkg::COORD_W-1:0] pos_y,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [31:0]                            blended_argb,
    output logic                                   write_enable
);
    import tapb_pkg::*;

    cfg_t   cfg;
    logic   fr_valid;
    logic   fr_ready;
    front_t fr_data;

    // Register file; live values feed the front stage directly
    tapb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage 1: clip test, weight and tinted targets
    tapb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .source_argb (source_argb),
        .dest_argb   (dest_argb),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .fr_valid    (fr_valid),
        .fr_ready    (fr_ready),
        .fr_data     (fr_data)
    );

    // Stages 2 and 3: per-channel product, then add and output register
    tapb_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .fr_valid     (fr_valid),
        .fr_ready     (fr_ready),
        .fr_data      (fr_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .blended_argb (blended_argb),
        .write_enable (write_enable)
    );

endmodule

`default_nettype wire

### design/tapb_checker.sv
`default_nettype none

module tapb_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] blended_argb,
    input  wire logic        write_enable
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blended_argb) && $stable(write_enable))
        else $error("output beat changed while stalled");

    // Free-running sink never back-pressures the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with room in the pipeline");

    // An accepted beat reaches the output when the sink keeps up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind tinted_alpha_pixel_blender tapb_checker u_tapb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blended_argb (blended_argb),
    .write_enable (write_enable)
);

`default_nettype wire
